FILE: hdl/tsshm_pkg.sv
package tsshm_pkg;

  localparam int unsigned DATA_W = 32;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;
  localparam logic [1:0] OP_SHOW = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  typedef struct packed {
    logic [1:0]               op;
    logic                     which_stack;
    logic signed [DATA_W-1:0] data_in;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    logic [1:0]               status;
    logic                     last;
  } out_word_t;

endpackage

FILE: hdl/tsshm_ram.sv
module tsshm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/two_stacks_shared_memory_core.sv
// Two stacks sharing one memory of DEPTH words. Stack 0 grows up from entry 0,
// stack 1 grows down from entry DEPTH-1.
// Input channel (in_valid/in_ready/in_data): one word asks for push, pop, peek
// or show on one stack. Result channel (out_valid/out_ready/out_data): every
// input word gives one result, except show on a non-empty stack, which gives
// one result per element, top to bottom; last marks the final result.
// Latency: the first result is valid the cycle after the input word is taken;
// the memory read of pop, peek and show is that cycle. Show then streams one
// element per cycle while out_ready is high, set by the single memory read
// port, whose registered output doubles as the result data register.
// Throughput: one input word per cycle while results are taken at once and no
// show streams; a new word is taken in the same cycle as the prior final result.
// A stalled receiver holds the result: the memory re-reads the same entry, and
// in_ready stays low until the final result leaves.
// Reset (rst_n low, synchronous): both stacks empty, no result pending. The
// memory is not cleared; only pushed entries ever reach data_out.
module two_stacks_shared_memory_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tsshm_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tsshm_pkg::out_word_t out_data
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
  localparam logic [AW-1:0] ADDR_TOP = AW'(DEPTH - 1);

  logic [CW-1:0] low_cnt_r,  low_cnt_nxt;
  logic [CW-1:0] high_base_r, high_base_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          show_r,      show_nxt;
  logic          down_r,      down_nxt;
  logic          sel_r,       sel_nxt;
  logic [1:0]    status_r,    status_nxt;
  logic          last_r,      last_nxt;
  logic [AW-1:0] cur_addr_r;

  logic [AW-1:0]                    rd_addr;
  logic [tsshm_pkg::DATA_W-1:0]     rd_data;
  logic                             wr_en;
  logic [AW-1:0]                    wr_addr;
  logic                             in_acc;
  logic                             out_acc;
  logic                             empty;
  logic                             full;
  logic [AW-1:0]                    top_addr;
  logic [CW-1:0]                    low_dec;
  logic [CW-1:0]                    high_dec;

  tsshm_ram #(
    .WIDTH(tsshm_pkg::DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(in_data.data_in),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  assign out_acc  = out_valid_r && out_ready;
  assign in_ready = !out_valid_r || (out_ready && last_r);
  assign in_acc   = in_valid && in_ready;

  assign low_dec  = low_cnt_r - CW'(1);
  assign high_dec = high_base_r - CW'(1);
  assign full     = (low_cnt_r >= high_base_r);
  assign empty    = in_data.which_stack ? (high_base_r >= CNT_FULL)
                                        : (low_cnt_r == '0);
  assign top_addr = in_data.which_stack ? high_base_r[AW-1:0] : low_dec[AW-1:0];

  always_comb begin
    low_cnt_nxt   = low_cnt_r;
    high_base_nxt = high_base_r;
    out_valid_nxt = out_valid_r;
    show_nxt      = show_r;
    down_nxt      = down_r;
    sel_nxt       = sel_r;
    status_nxt    = status_r;
    last_nxt      = last_r;
    rd_addr       = cur_addr_r;
    wr_en         = 1'b0;
    wr_addr       = in_data.which_stack ? high_dec[AW-1:0] : low_cnt_r[AW-1:0];

    if (out_acc) begin
      out_valid_nxt = 1'b0;
      if (show_r && !last_r) begin
        rd_addr       = down_r ? cur_addr_r - AW'(1) : cur_addr_r + AW'(1);
        out_valid_nxt = 1'b1;
        last_nxt      = down_r ? (rd_addr == '0) : (rd_addr == ADDR_TOP);
      end
    end

    if (in_acc) begin
      out_valid_nxt = 1'b1;
      show_nxt      = 1'b0;
      sel_nxt       = 1'b0;
      last_nxt      = 1'b1;
      down_nxt      = !in_data.which_stack;
      case (in_data.op)
        tsshm_pkg::OP_PUSH: begin
          if (full) begin
            status_nxt = tsshm_pkg::ST_OVERFLOW;
          end else begin
            status_nxt = tsshm_pkg::ST_OK;
            wr_en      = 1'b1;
            if (in_data.which_stack) begin
              high_base_nxt = high_dec;
            end else begin
              low_cnt_nxt = low_cnt_r + CW'(1);
            end
          end
        end
        tsshm_pkg::OP_POP, tsshm_pkg::OP_PEEK: begin
          if (empty) begin
            status_nxt = tsshm_pkg::ST_EMPTY;
          end else begin
            status_nxt = tsshm_pkg::ST_OK;
            sel_nxt    = 1'b1;
            rd_addr    = top_addr;
            if (in_data.op == tsshm_pkg::OP_POP) begin
              if (in_data.which_stack) begin
                high_base_nxt = high_base_r + CW'(1);
              end else begin
                low_cnt_nxt = low_dec;
              end
            end
          end
        end
        default: begin
          if (empty) begin
            status_nxt = tsshm_pkg::ST_EMPTY;
          end else begin
            status_nxt = tsshm_pkg::ST_OK;
            sel_nxt    = 1'b1;
            show_nxt   = 1'b1;
            rd_addr    = top_addr;
            last_nxt   = in_data.which_stack ? (top_addr == ADDR_TOP)
                                             : (top_addr == '0);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_cnt_r   <= '0;
      high_base_r <= CNT_FULL;
      out_valid_r <= 1'b0;
      show_r      <= 1'b0;
    end else begin
      low_cnt_r   <= low_cnt_nxt;
      high_base_r <= high_base_nxt;
      out_valid_r <= out_valid_nxt;
      show_r      <= show_nxt;
    end
    down_r     <= down_nxt;
    sel_r      <= sel_nxt;
    status_r   <= status_nxt;
    last_r     <= last_nxt;
    cur_addr_r <= rd_addr;
  end

  assign out_valid         = out_valid_r;
  assign out_data.data_out = sel_r ? $signed(rd_data) : '0;
  assign out_data.status   = status_r;
  assign out_data.last     = last_r;

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted word produced no result");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    low_cnt_r <= high_base_r)
    else $error("stacks overlap");

  a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
    high_base_r <= CNT_FULL)
    else $error("stack 1 base beyond memory");

  a_status_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r != tsshm_pkg::ST_OK) |-> last_r && !sel_r)
    else $error("status result not final or carries data");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  tsshm_pkg::in_word_t  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  tsshm_pkg::out_word_t out_data;

  logic [tsshm_pkg::DATA_W-1:0] model_mem [DEPTH];
  int unsigned                  low_count = 0;
  int unsigned                  high_base = DEPTH;
  tsshm_pkg::out_word_t         pending_results [$];

  bit          no_idle = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned words_sent = 0;
  int unsigned results_checked = 0;
  int unsigned overflows_seen = 0;
  int unsigned empties_seen = 0;

  two_stacks_shared_memory_core #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(0, 99) >= 22);
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    tsshm_pkg::out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, data_out", out_data.data_out, '0);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_data.data_out !== want.data_out)
          report_mismatch("data_out", out_data.data_out, want.data_out);
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
        if (out_data.last !== want.last)
          report_mismatch("last", 32'(out_data.last), 32'(want.last));
      end
    end
  end

  function automatic tsshm_pkg::out_word_t result_word(
      input logic [tsshm_pkg::DATA_W-1:0] value, input logic [1:0] st, input logic fin);
    tsshm_pkg::out_word_t r;
    r.data_out = value;
    r.status   = st;
    r.last     = fin;
    return r;
  endfunction

  task automatic predict_stack_results(input tsshm_pkg::in_word_t w);
    bit          is_empty;
    int unsigned top;
    is_empty = (w.which_stack == 1'b0) ? (low_count == 0) : (high_base >= DEPTH);
    if (w.op == tsshm_pkg::OP_PUSH) begin
      if (low_count >= high_base) begin
        pending_results.push_back(result_word('0, tsshm_pkg::ST_OVERFLOW, 1'b1));
        overflows_seen++;
      end else begin
        if (w.which_stack == 1'b0) begin
          model_mem[low_count] = w.data_in;
          low_count++;
        end else begin
          high_base--;
          model_mem[high_base] = w.data_in;
        end
        pending_results.push_back(result_word('0, tsshm_pkg::ST_OK, 1'b1));
      end
    end else if (is_empty) begin
      pending_results.push_back(result_word('0, tsshm_pkg::ST_EMPTY, 1'b1));
      empties_seen++;
    end else if (w.op == tsshm_pkg::OP_POP || w.op == tsshm_pkg::OP_PEEK) begin
      top = (w.which_stack == 1'b0) ? low_count - 1 : high_base;
      pending_results.push_back(result_word(model_mem[top], tsshm_pkg::ST_OK, 1'b1));
      if (w.op == tsshm_pkg::OP_POP) begin
        if (w.which_stack == 1'b0) low_count--;
        else high_base++;
      end
    end else if (w.which_stack == 1'b0) begin
      for (int i = int'(low_count) - 1; i >= 0; i--)
        pending_results.push_back(result_word(model_mem[i], tsshm_pkg::ST_OK, i == 0));
    end else begin
      for (int unsigned i = high_base; i < DEPTH; i++)
        pending_results.push_back(result_word(model_mem[i], tsshm_pkg::ST_OK,
                                              i == DEPTH - 1));
    end
  endtask

  function automatic tsshm_pkg::in_word_t make_word(input logic [1:0] op,
      input logic which, input logic [tsshm_pkg::DATA_W-1:0] value);
    tsshm_pkg::in_word_t w;
    w.op          = op;
    w.which_stack = which;
    w.data_in     = value;
    return w;
  endfunction

  function automatic logic [tsshm_pkg::DATA_W-1:0] random_value();
    case ($urandom_range(0, 11))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input tsshm_pkg::in_word_t w);
    while (!no_idle && $urandom_range(0, 99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    predict_stack_results(w);
    words_sent++;
  endtask

  task automatic test_empty_stacks();
    for (int s = 0; s < 2; s++) begin
      send_word(make_word(tsshm_pkg::OP_POP, s[0], $urandom));
      send_word(make_word(tsshm_pkg::OP_PEEK, s[0], $urandom));
      send_word(make_word(tsshm_pkg::OP_SHOW, s[0], $urandom));
    end
  endtask

  task automatic test_push_extremes();
    send_word(make_word(tsshm_pkg::OP_PUSH, 1'b0, 32'h8000_0000));
    send_word(make_word(tsshm_pkg::OP_PUSH, 1'b0, 32'h7fff_ffff));
    send_word(make_word(tsshm_pkg::OP_PUSH, 1'b1, 32'h0000_0000));
    send_word(make_word(tsshm_pkg::OP_PUSH, 1'b1, 32'hffff_ffff));
  endtask

  task automatic test_overflow();
    while (low_count < high_base)
      send_word(make_word(tsshm_pkg::OP_PUSH, low_count[0], random_value()));
    send_word(make_word(tsshm_pkg::OP_PUSH, 1'b0, random_value()));
    send_word(make_word(tsshm_pkg::OP_PUSH, 1'b1, random_value()));
    send_word(make_word(tsshm_pkg::OP_SHOW, 1'b1, $urandom));
  endtask

  task automatic test_fill_and_drain();
    while (low_count < high_base)
      send_word(make_word(tsshm_pkg::OP_PUSH, 1'($urandom_range(0, 1)), random_value()));
    send_word(make_word(tsshm_pkg::OP_PUSH, 1'($urandom_range(0, 1)), random_value()));
    send_word(make_word(tsshm_pkg::OP_SHOW, 1'b0, $urandom));
    send_word(make_word(tsshm_pkg::OP_SHOW, 1'b1, $urandom));
    while (low_count != 0 || high_base != DEPTH)
      send_word(make_word($urandom_range(0, 1) ? tsshm_pkg::OP_POP : tsshm_pkg::OP_PEEK,
                          (low_count == 0) ? 1'b1 : (high_base == DEPTH) ? 1'b0 :
                          1'($urandom_range(0, 1)), $urandom));
    send_word(make_word(tsshm_pkg::OP_POP, 1'b0, $urandom));
    send_word(make_word(tsshm_pkg::OP_POP, 1'b1, $urandom));
  endtask

  task automatic run_random_traffic(input int unsigned n_words);
    int unsigned stop_at;
    int unsigned burst;
    logic        which;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      which = 1'($urandom_range(0, 1));
      burst = $urandom_range(1, 6);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: repeat (burst)
          send_word(make_word(tsshm_pkg::OP_PUSH, which, random_value()));
        4, 5, 6: repeat (burst) send_word(make_word(tsshm_pkg::OP_POP, which, $urandom));
        7: begin
          send_word(make_word(tsshm_pkg::OP_SHOW, which, $urandom));
          send_word(make_word(tsshm_pkg::OP_PEEK, which, $urandom));
        end
        default: send_word(make_word(2'($urandom_range(0, 3)), which, $urandom));
      endcase
    end
  endtask

  task automatic test_random_mix();
    run_random_traffic(120);
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    run_random_traffic(45);
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_stacks();
    test_push_extremes();
    test_overflow();
    test_fill_and_drain();
    test_random_mix();
    test_back_to_back();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("run covered %0d input words and %0d checked results", words_sent,
             results_checked);
    $display("including %0d overflow and %0d empty-stack responses", overflows_seen,
             empties_seen);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", error_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
